/* rtl/core/rtd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtd_pkg
// Shared constants, types and helpers of the resonance term derivative unit.
// ----------------------------------------------------------------------------
package rtd_pkg;

    localparam int ORDER_MAX_DEF    = 8;
    localparam int CORDIC_STEPS_DEF = 32;
    localparam int TAB_LEN          = 40;

    // all intermediates are kept in 62 bit signed, limited to +-(2^60-1)
    localparam int VW = 62;
    localparam logic signed [VW-1:0] LIM = 62'sh0FFF_FFFF_FFFF_FFFF;
    localparam logic signed [VW-1:0] OUT_MAX = 62'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [VW-1:0] CORDIC_GAIN = 62'sh26DD_3B6A;
    localparam logic signed [VW-1:0] ONE_Q28 = 62'sh1000_0000;

    // arctangent table in 2^-32 turn units
    function automatic logic [31:0] atan_turns(input logic [5:0] i);
        logic [31:0] r;
        begin
            case (i)
                6'd0:  r = 32'h20000000;
                6'd1:  r = 32'h12E4051E;
                6'd2:  r = 32'h09FB385B;
                6'd3:  r = 32'h051111D4;
                6'd4:  r = 32'h028B0D43;
                6'd5:  r = 32'h0145D7E1;
                6'd6:  r = 32'h00A2F61E;
                6'd7:  r = 32'h00517C55;
                6'd8:  r = 32'h0028BE53;
                6'd9:  r = 32'h00145F2F;
                6'd10: r = 32'h000A2F98;
                6'd11: r = 32'h000517CC;
                6'd12: r = 32'h00028BE6;
                6'd13: r = 32'h000145F3;
                6'd14: r = 32'h0000A2FA;
                6'd15: r = 32'h0000517D;
                6'd16: r = 32'h000028BE;
                6'd17: r = 32'h0000145F;
                6'd18: r = 32'h00000A30;
                6'd19: r = 32'h00000518;
                6'd20: r = 32'h0000028C;
                6'd21: r = 32'h00000146;
                6'd22: r = 32'h000000A3;
                6'd23: r = 32'h00000051;
                6'd24: r = 32'h00000029;
                6'd25: r = 32'h00000014;
                6'd26: r = 32'h0000000A;
                6'd27: r = 32'h00000005;
                6'd28: r = 32'h00000003;
                6'd29: r = 32'h00000001;
                6'd30: r = 32'h00000001;
                default: r = 32'h0;
            endcase
            return r;
        end
    endfunction

    function automatic logic signed [VW-1:0] clampl(input logic signed [VW:0] v);
        logic signed [VW-1:0] r;
        begin
            if (v > $signed({LIM[VW-1], LIM}))
                r = LIM;
            else if (v < -$signed({LIM[VW-1], LIM}))
                r = -LIM;
            else
                r = v[VW-1:0];
            return r;
        end
    endfunction

    // multiplier command to the shared unit
    typedef struct packed {
        logic signed [VW-1:0] a;
        logic signed [VW-1:0] b;
        logic [4:0]           sh;
    } rtd_mul_req_t;

endpackage

/* rtl/core/rtd_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtd_mul
// Shared multi-cycle magnitude multiplier: four 32x32 partial products,
// accumulated in turn, then shift, truncation toward zero and saturation.
// ----------------------------------------------------------------------------
module rtd_mul
    import rtd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  rtd_mul_req_t         req,
    output logic                 done,
    output logic signed [VW-1:0] result
);

    logic [63:0]  ua_reg, ub_reg;
    logic         neg_reg;
    logic [4:0]   sh_reg;
    logic [127:0] acc_reg;
    logic [2:0]   cnt_reg;
    logic         busy_reg;
    logic signed [VW-1:0] result_reg;
    logic         done_reg;

    logic [63:0]  ua_in, ub_in;
    logic [31:0]  pa, pb;
    logic [63:0]  pp;
    logic [127:0] pp_sh;
    logic [127:0] acc_sum;
    logic [127:0] shifted;
    logic [63:0]  mag;

    // operand magnitudes
    always_comb
    begin
        ua_in = req.a[VW-1] ? 64'(-req.a) : 64'(req.a);
        ub_in = req.b[VW-1] ? 64'(-req.b) : 64'(req.b);
    end

    // one partial product per cycle
    always_comb
    begin
        pa = cnt_reg[0] ? ua_reg[63:32] : ua_reg[31:0];
        pb = cnt_reg[1] ? ub_reg[63:32] : ub_reg[31:0];
        pp = 64'(pa) * 64'(pb);
        pp_sh = 128'(pp) << (7'(cnt_reg[0]) * 7'd32 + 7'(cnt_reg[1]) * 7'd32);
        acc_sum = acc_reg + pp_sh;
        shifted = acc_reg >> sh_reg;
        mag = (shifted[127:60] != '0) ? 64'(LIM) : shifted[63:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !start && (cnt_reg == 3'd4);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                ua_reg   <= ua_in;
                ub_reg   <= ub_in;
                neg_reg  <= req.a[VW-1] ^ req.b[VW-1];
                sh_reg   <= req.sh;
                acc_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == 3'd4)
                begin
                    busy_reg   <= 1'b0;
                    result_reg <= neg_reg ? -$signed(mag[VW-1:0]) : $signed(mag[VW-1:0]);
                end
                else
                begin
                    acc_reg <= acc_sum;
                    cnt_reg <= cnt_reg + 3'd1;
                end
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* rtl/core/rtd_cordic.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtd_cordic
// Rotation-mode CORDIC, one micro-rotation per cycle, with quadrant fold.
// ----------------------------------------------------------------------------
module rtd_cordic
    import rtd_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [31:0]          angle,
    output logic                 done,
    output logic signed [VW-1:0] cos_out,
    output logic signed [VW-1:0] sin_out
);

    localparam int NSTEP = (CORDIC_STEPS > TAB_LEN) ? TAB_LEN : CORDIC_STEPS;

    logic signed [VW-1:0] x_reg, y_reg;
    logic signed [33:0]   z_reg;
    logic [5:0]           i_reg;
    logic                 flip_reg, busy_reg, done_reg;

    logic [31:0]          sum_q;
    logic                 flip_in;
    logic [31:0]          ang_f;
    logic signed [VW-1:0] dx, dy;
    logic signed [33:0]   at;

    always_comb
    begin
        sum_q   = angle + 32'h4000_0000;
        flip_in = sum_q[31];
        ang_f   = flip_in ? angle - 32'h8000_0000 : angle;
        dx      = y_reg >>> i_reg;
        dy      = x_reg >>> i_reg;
        at      = $signed({2'b00, atan_turns(i_reg)});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !start && (i_reg == 6'(NSTEP));
            if (start)
            begin
                busy_reg <= 1'b1;
                flip_reg <= flip_in;
                x_reg    <= CORDIC_GAIN;
                y_reg    <= '0;
                z_reg    <= 34'($signed(ang_f));
                i_reg    <= '0;
            end
            else if (busy_reg)
            begin
                if (i_reg == 6'(NSTEP))
                begin
                    busy_reg <= 1'b0;
                    if (flip_reg)
                    begin
                        x_reg <= -x_reg;
                        y_reg <= -y_reg;
                    end
                end
                else
                begin
                    // micro-rotation
                    if (!z_reg[33])
                    begin
                        x_reg <= x_reg - dx;
                        y_reg <= y_reg + dy;
                        z_reg <= z_reg - at;
                    end
                    else
                    begin
                        x_reg <= x_reg + dx;
                        y_reg <= y_reg - dy;
                        z_reg <= z_reg + at;
                    end
                    i_reg <= i_reg + 6'd1;
                end
            end
        end
    end

    assign done    = done_reg;
    assign cos_out = x_reg;
    assign sin_out = y_reg;

endmodule

/* rtl/core/rtd_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtd_seq
// Sequencer: eccentricity power, eps, complex powers, rotated terms and the
// twelve finished outputs, all through the shared multiplier.
// ----------------------------------------------------------------------------
module rtd_seq
    import rtd_pkg::*;
#(
    parameter int ORDER_MAX    = ORDER_MAX_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [31:0]  coord_x,
    input  logic signed [31:0]  coord_y,
    input  logic [31:0]         particle_longitude,
    input  logic [7:0]          j_index,
    input  logic [3:0]          order_k,
    input  logic [3:0]          split_l,
    input  logic                inner_perturber,
    input  logic signed [31:0]  term_coeff,
    input  logic [28:0]         perturber_ecc,
    input  logic [31:0]         perturber_longitude,
    input  logic [31:0]         perturber_pericenter,
    output logic                finished,
    output logic [47:0]         res [12]
);

    typedef enum logic [3:0] {
        S_IDLE, S_ANGLE, S_CORDIC, S_EPOW, S_EPS, S_POW,
        S_ROT, S_FIN_A, S_FIN_B, S_DONE
    } state_t;

    state_t state_reg;

    logic signed [VW-1:0] x_reg, y_reg, coeff_reg, ecc_reg;
    logic [31:0]          lin_reg, lout_reg, pom_reg;
    logic [7:0]           j_reg;
    logic [4:0]           k_reg;
    logic [4:0]           p_reg, pp_reg;
    logic signed [9:0]    d_reg;
    logic signed [VW-1:0] epow_reg, eps_reg, re_reg, im_reg;
    logic signed [VW-1:0] pr_reg [3];
    logic signed [VW-1:0] pi_reg [3];
    logic signed [VW-1:0] cm_reg [3];
    logic signed [VW-1:0] sm_reg [3];
    logic signed [VW-1:0] t_reg [4];
    logic [4:0]           n_reg;
    logic [3:0]           o_reg;
    logic [1:0]           m_reg;
    logic [1:0]           ph_reg;
    logic                 busy_mul_reg;
    logic [31:0]          phi_reg;
    logic                 cstart_reg;
    logic [47:0]          res_reg [12];

    logic                 mstart;
    rtd_mul_req_t         mreq;
    logic                 mdone;
    logic signed [VW-1:0] mres;
    logic                 cdone;
    logic signed [VW-1:0] cs, sn;

    logic [4:0]           k_c, l_c;
    logic [4:0]           p_c, pp_c;
    logic signed [9:0]    d_c;
    logic signed [VW-1:0] term_sel;
    logic signed [VW-1:0] fac_sel;
    logic signed [VW-1:0] fin_sel;
    logic signed [VW-1:0] mc_a, mc_b;

    rtd_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mstart),
        .req    (mreq),
        .done   (mdone),
        .result (mres)
    );

    rtd_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cstart_reg),
        .angle   (phi_reg),
        .done    (cdone),
        .cos_out (cs),
        .sin_out (sn)
    );

    // order and split limits, roles of the two bodies
    always_comb
    begin
        k_c = (5'(order_k) > 5'(ORDER_MAX)) ? 5'(ORDER_MAX) : 5'(order_k);
        l_c = (5'(split_l) > k_c) ? k_c : 5'(split_l);
        if (inner_perturber)
        begin
            p_c  = k_c - l_c;
            pp_c = l_c;
            d_c  = 10'(j_index);
        end
        else
        begin
            p_c  = l_c;
            pp_c = k_c - l_c;
            d_c  = 10'(k_c) - 10'(j_index);
        end
    end

    // term and integer factor of each output
    always_comb
    begin
        case (o_reg)
            4'd0:    begin term_sel = cm_reg[1]; fac_sel = VW'(p_reg); end
            4'd1:    begin term_sel = sm_reg[0]; fac_sel = VW'(d_reg); end
            4'd2:    begin term_sel = sm_reg[1]; fac_sel = VW'(p_reg); end
            4'd3:    begin term_sel = sm_reg[1]; fac_sel = -(VW'(p_reg) * VW'(d_reg)); end
            4'd4:    begin term_sel = sm_reg[2];
                           fac_sel = -(VW'(p_reg) * (VW'(p_reg) - 1)); end
            4'd5:    begin term_sel = cm_reg[2]; fac_sel = VW'(p_reg) * (VW'(p_reg) - 1); end
            4'd6:    begin term_sel = cm_reg[0]; fac_sel = VW'(d_reg) * VW'(d_reg); end
            4'd7:    begin term_sel = cm_reg[1]; fac_sel = VW'(p_reg) * VW'(d_reg); end
            4'd8:    begin term_sel = sm_reg[1]; fac_sel = VW'(p_reg) * VW'(d_reg); end
            4'd9:    begin term_sel = cm_reg[1]; fac_sel = VW'(p_reg) * VW'(d_reg); end
            4'd10:   begin term_sel = cm_reg[2]; fac_sel = VW'(p_reg) * (VW'(p_reg) - 1); end
            default: begin term_sel = sm_reg[2]; fac_sel = VW'(p_reg) * (VW'(p_reg) - 1); end
        endcase
        if (mres > OUT_MAX)
            fin_sel = OUT_MAX;
        else if (mres < -OUT_MAX - 1)
            fin_sel = -OUT_MAX - 1;
        else
            fin_sel = mres;
    end

    // operands for the complex power and rotation phases
    always_comb
    begin
        mc_a = '0;
        mc_b = '0;
        if (state_reg == S_POW)
        begin
            mc_a = ph_reg[0] ? im_reg : re_reg;
            mc_b = (ph_reg[0] ^ ph_reg[1]) ? y_reg : x_reg;
        end
        else
        begin
            mc_a = ph_reg[0] ? pi_reg[m_reg] : pr_reg[m_reg];
            mc_b = (ph_reg[0] ^ ph_reg[1]) ? sn : cs;
        end
    end

    // multiplier issue
    always_comb
    begin
        mstart = 1'b0;
        mreq   = '0;
        if (!busy_mul_reg)
        begin
            unique case (state_reg)
                S_EPOW:
                begin
                    mstart = (n_reg != pp_reg);
                    mreq   = '{a: epow_reg, b: ecc_reg, sh: 5'd28};
                end
                S_EPS:
                begin
                    mstart = 1'b1;
                    mreq   = '{a: coeff_reg, b: epow_reg, sh: 5'd24};
                end
                S_POW:
                begin
                    mstart = 1'b1;
                    mreq   = '{a: mc_a, b: mc_b, sh: 5'd28};
                end
                S_ROT:
                begin
                    mstart = 1'b1;
                    mreq   = '{a: mc_a, b: mc_b, sh: 5'd30};
                end
                S_FIN_A:
                begin
                    mstart = 1'b1;
                    mreq   = '{a: eps_reg, b: term_sel, sh: 5'd24};
                end
                S_FIN_B:
                begin
                    mstart = 1'b1;
                    mreq   = '{a: t_reg[0], b: fac_sel, sh: 5'd0};
                end
                default:
                begin
                    mstart = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            busy_mul_reg <= 1'b0;
            cstart_reg   <= 1'b0;
            finished     <= 1'b0;
        end
        else
        begin
            // cordic starts once the angle register holds the new angle
            cstart_reg <= (state_reg == S_ANGLE);
            finished   <= (state_reg == S_DONE);
            if (mstart)
                busy_mul_reg <= 1'b1;
            else if (mdone)
                busy_mul_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        x_reg     <= VW'(coord_x);
                        y_reg     <= VW'(coord_y);
                        coeff_reg <= VW'(term_coeff);
                        ecc_reg   <= VW'($signed({1'b0, perturber_ecc}));
                        lin_reg   <= inner_perturber ? perturber_longitude : particle_longitude;
                        lout_reg  <= inner_perturber ? particle_longitude : perturber_longitude;
                        pom_reg   <= perturber_pericenter;
                        j_reg     <= j_index;
                        k_reg     <= k_c;
                        p_reg     <= p_c;
                        pp_reg    <= pp_c;
                        d_reg     <= d_c;
                        state_reg <= S_ANGLE;
                    end
                end
                S_ANGLE:
                begin
                    // resonant angle, wraps modulo one turn
                    phi_reg <= 32'(j_reg) * lout_reg
                             - (32'(j_reg) - 32'(k_reg)) * lin_reg
                             - 32'(pp_reg) * pom_reg;
                    state_reg <= S_CORDIC;
                end
                S_CORDIC:
                begin
                    if (cdone)
                    begin
                        n_reg     <= '0;
                        epow_reg  <= ONE_Q28;
                        state_reg <= S_EPOW;
                    end
                end
                S_EPOW:
                begin
                    if (!busy_mul_reg && n_reg == pp_reg)
                        state_reg <= S_EPS;
                    else if (mdone)
                    begin
                        epow_reg <= mres;
                        n_reg    <= n_reg + 5'd1;
                    end
                end
                S_EPS:
                begin
                    if (mdone)
                    begin
                        eps_reg <= -mres;
                        re_reg  <= ONE_Q28;
                        im_reg  <= '0;
                        for (int q = 0; q < 3; q++)
                        begin
                            pr_reg[q] <= '0;
                            pi_reg[q] <= '0;
                        end
                        n_reg     <= '0;
                        ph_reg    <= '0;
                        state_reg <= S_POW;
                    end
                end
                S_POW:
                begin
                    if (mdone)
                    begin
                        t_reg[ph_reg] <= mres;
                        ph_reg        <= ph_reg + 2'd1;
                        if (ph_reg == 2'd3)
                        begin
                            // captured power before stepping
                            if (n_reg == p_reg)
                            begin
                                pr_reg[0] <= re_reg; pi_reg[0] <= im_reg;
                            end
                            if (n_reg + 5'd1 == p_reg)
                            begin
                                pr_reg[1] <= re_reg; pi_reg[1] <= im_reg;
                            end
                            if (n_reg + 5'd2 == p_reg)
                            begin
                                pr_reg[2] <= re_reg; pi_reg[2] <= im_reg;
                            end
                            re_reg <= clampl({t_reg[0][VW-1], t_reg[0]}
                                             - {t_reg[1][VW-1], t_reg[1]});
                            im_reg <= clampl({t_reg[2][VW-1], t_reg[2]}
                                             + {mres[VW-1], mres});
                            if (n_reg == p_reg)
                            begin
                                m_reg     <= '0;
                                state_reg <= S_ROT;
                            end
                            n_reg <= n_reg + 5'd1;
                        end
                    end
                end
                S_ROT:
                begin
                    // phases: re*cs, im*sn, re*sn, im*cs
                    if (mdone)
                    begin
                        t_reg[ph_reg] <= mres;
                        ph_reg        <= ph_reg + 2'd1;
                        if (ph_reg == 2'd3)
                        begin
                            cm_reg[m_reg] <= clampl({t_reg[0][VW-1], t_reg[0]}
                                                    - {t_reg[1][VW-1], t_reg[1]});
                            sm_reg[m_reg] <= clampl({t_reg[2][VW-1], t_reg[2]}
                                                    + {mres[VW-1], mres});
                            m_reg <= m_reg + 2'd1;
                            if (m_reg == 2'd2)
                            begin
                                o_reg     <= '0;
                                state_reg <= S_FIN_A;
                            end
                        end
                    end
                end
                S_FIN_A:
                begin
                    if (mdone)
                    begin
                        t_reg[0]  <= mres;
                        state_reg <= S_FIN_B;
                    end
                end
                S_FIN_B:
                begin
                    if (mdone)
                    begin
                        res_reg[o_reg] <= fin_sel[47:0];
                        if (o_reg == 4'd11)
                            state_reg <= S_DONE;
                        else
                        begin
                            o_reg     <= o_reg + 4'd1;
                            state_reg <= S_FIN_A;
                        end
                    end
                end
                S_DONE:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign res = res_reg;

endmodule

/* rtl/core/resonance_term_derivatives_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resonance_term_derivatives_unit
// Derivative rates and Jacobian entries of one resonance term.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready take one term with coordinates and angles; out_valid/
//   out_ready deliver the three rates and nine Jacobian entries together.
//   The term is worked on by a small sequencer around one shared multi-cycle
//   multiplier and a one-step-a-cycle CORDIC; one term is in flight at a time.
//   The result sits in an output register; the next term is taken while
//   it waits, and the unit stalls only when a second result would need
//   the same register before the first is transferred.
//   Reset clears out_valid and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module resonance_term_derivatives_unit
    import rtd_pkg::*;
#(
    parameter int ORDER_MAX    = ORDER_MAX_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] coord_y,
    input  logic [31:0]        particle_longitude,
    input  logic [7:0]         j_index,
    input  logic [3:0]         order_k,
    input  logic [3:0]         split_l,
    input  logic               inner_perturber,
    input  logic signed [31:0] term_coeff,
    input  logic [28:0]        perturber_ecc,
    input  logic [31:0]        perturber_longitude,
    input  logic [31:0]        perturber_pericenter,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [47:0] rate_y,
    output logic signed [47:0] rate_momentum,
    output logic signed [47:0] rate_x,
    output logic signed [47:0] jac_r1_c0,
    output logic signed [47:0] jac_r1_c1,
    output logic signed [47:0] jac_r1_c3,
    output logic signed [47:0] jac_r2_c0,
    output logic signed [47:0] jac_r2_c1,
    output logic signed [47:0] jac_r2_c3,
    output logic signed [47:0] jac_r3_c0,
    output logic signed [47:0] jac_r3_c1,
    output logic signed [47:0] jac_r3_c3
);

    logic        busy_reg;
    logic        out_valid_reg;
    logic [47:0] out_reg [12];
    logic        fin;
    logic [47:0] res [12];
    logic        take;
    logic        fin_pending;
    logic        fin_hold_reg;

    assign in_ready = !busy_reg;
    assign take     = in_valid && in_ready;

    rtd_seq #(.ORDER_MAX(ORDER_MAX), .CORDIC_STEPS(CORDIC_STEPS)) u_seq (
        .clk                  (clk),
        .rst_n                (rst_n),
        .start                (take),
        .coord_x              (coord_x),
        .coord_y              (coord_y),
        .particle_longitude   (particle_longitude),
        .j_index              (j_index),
        .order_k              (order_k),
        .split_l              (split_l),
        .inner_perturber      (inner_perturber),
        .term_coeff           (term_coeff),
        .perturber_ecc        (perturber_ecc),
        .perturber_longitude  (perturber_longitude),
        .perturber_pericenter (perturber_pericenter),
        .finished             (fin),
        .res                  (res)
    );

    // busy from transfer in until the result lands in a free output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (busy_reg && fin_pending && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
                out_reg       <= res;
                busy_reg      <= 1'b0;
            end
            else
            begin
                if (out_valid_reg && out_ready)
                    out_valid_reg <= 1'b0;
                if (take)
                    busy_reg <= 1'b1;
            end
        end
    end

    // finished result held until the output register is free
    assign fin_pending = fin || fin_hold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fin_hold_reg <= 1'b0;
        else if (fin_pending && (!out_valid_reg || out_ready))
            fin_hold_reg <= 1'b0;
        else if (fin)
            fin_hold_reg <= 1'b1;
    end

    assign out_valid     = out_valid_reg;
    assign rate_y        = out_reg[0];
    assign rate_momentum = out_reg[1];
    assign rate_x        = out_reg[2];
    assign jac_r1_c0     = out_reg[3];
    assign jac_r1_c1     = out_reg[4];
    assign jac_r1_c3     = out_reg[5];
    assign jac_r2_c0     = out_reg[6];
    assign jac_r2_c1     = out_reg[7];
    assign jac_r2_c3     = out_reg[8];
    assign jac_r3_c0     = out_reg[9];
    assign jac_r3_c1     = out_reg[10];
    assign jac_r3_c3     = out_reg[11];

endmodule
